### src/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg - shared types and constants for the port-mapped memory pager
// Window count, port codes, decode command and status encodings.
// ----------------------------------------------------------------------------
package mmp_pkg;

  localparam int NumWindows   = 4;
  localparam int RomPageCount = 32;
  localparam int WinIdxW      = $clog2(NumWindows);
  localparam int RomPageW     = $clog2(RomPageCount);

  // Port codes
  localparam logic [7:0]  LoShadow     = 8'hBF;
  localparam logic [7:0]  LoManager    = 8'h77;
  localparam logic [15:0] PortExtCtrl  = 16'hEFF7;
  localparam logic [11:0] PortPageMix  = 12'hFF7;
  localparam logic [11:0] PortPageRam  = 12'h7F7;
  localparam logic [15:0] PortLegacy   = 16'h7FFD;
  localparam logic [15:0] PortNvIdxA   = 16'hDFF7;
  localparam logic [15:0] PortNvIdxB   = 16'hDEF7;
  localparam logic [15:0] PortNvDataA  = 16'hBFF7;
  localparam logic [15:0] PortNvDataB  = 16'hBEF7;

  localparam logic [7:0]  PageReset    = 8'hFF;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SHADOW,
    CMD_MGR,
    CMD_EXT,
    CMD_PAGE,
    CMD_LEGACY,
    CMD_NVIDX
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SD_IGNORE = 2'd1,
    ST_UNHANDLED = 2'd2
  } status_t;

  // Mode registers
  typedef struct packed {
    logic [7:0] shadow;
    logic [7:0] mgr;
    logic [7:0] ext;
    logic [7:0] legacy;
    logic [7:0] nvidx;
  } mode_regs_t;

  // Decoded write
  typedef struct packed {
    cmd_kind_t          kind;
    logic [WinIdxW-1:0] win;
    logic [7:0]         page;
    logic               ram;
    logic [7:0]         value;
    logic               we;
    status_t            status;
  } cmd_t;

endpackage

### src/mmp_decode.sv
// ----------------------------------------------------------------------------
// mmp_decode - port decoder
// Priority decode of one port write into a register update command.
// ----------------------------------------------------------------------------
module mmp_decode (
  input  logic [15:0]        port_addr,
  input  logic [7:0]         write_value,
  input  mmp_pkg::mode_regs_t regs,
  output mmp_pkg::cmd_t      cmd
);
  import mmp_pkg::*;

  logic       shadow_open;
  logic [7:0] hi;
  logic [7:0] lo;
  logic [7:0] inv;
  logic [7:0] ram_sub;
  logic [7:0] mix_page;
  logic [7:0] ram_page;

  assign hi  = port_addr[15:8];
  assign lo  = port_addr[7:0];
  assign inv = ~write_value;
  assign shadow_open = regs.shadow[0] | ~regs.mgr[1];

  // RAM low-bit substitution from the legacy paging register
  always_comb begin
    if (regs.ext[2]) begin
      ram_sub = {inv[7:3], regs.legacy[2:0]};
    end else begin
      ram_sub = {inv[7:6], regs.legacy[7:5], regs.legacy[2:0]};
    end
  end

  always_comb begin
    if (write_value[6]) begin
      if (write_value[7]) begin
        mix_page = {2'b00, ram_sub[5:0]};
      end else begin
        mix_page = {2'b00, inv[5:0]};
      end
    end else begin
      if (write_value[7]) begin
        mix_page = {3'b000, inv[4:1], ~regs.mgr[1]};
      end else begin
        mix_page = {3'b000, inv[4:0]};
      end
    end
    ram_page = write_value[7] ? ram_sub : inv;
  end

  always_comb begin
    cmd        = '0;
    cmd.kind   = CMD_NONE;
    cmd.status = ST_OK;
    cmd.win    = hi[7:6];
    cmd.value  = write_value;
    if (lo == LoShadow) begin
      cmd.kind = CMD_SHADOW;
    end else if (lo == LoManager && shadow_open) begin
      cmd.kind  = CMD_MGR;
      cmd.value = hi;
    end else if (port_addr == PortExtCtrl) begin
      cmd.kind = CMD_EXT;
    end else if (port_addr[11:0] == PortPageMix && shadow_open) begin
      cmd.kind = CMD_PAGE;
      cmd.page = mix_page;
      cmd.ram  = write_value[6];
    end else if (port_addr[11:0] == PortPageRam && shadow_open) begin
      cmd.kind = CMD_PAGE;
      cmd.page = ram_page;
      cmd.ram  = 1'b1;
    end else if (port_addr == PortLegacy) begin
      cmd.kind = CMD_LEGACY;
    end else if (port_addr == PortNvIdxA && !shadow_open) begin
      cmd.kind = CMD_NVIDX;
    end else if (port_addr == PortNvIdxB && shadow_open) begin
      cmd.kind = CMD_NVIDX;
    end else if (port_addr == PortNvDataA && !shadow_open) begin
      cmd.we = regs.ext[7];
    end else if (port_addr == PortNvDataB && shadow_open) begin
      cmd.we = 1'b1;
    end else if (lo == LoManager) begin
      cmd.status = ST_SD_IGNORE;
    end else begin
      cmd.status = ST_UNHANDLED;
    end
  end

endmodule

### src/mmp_state.sv
// ----------------------------------------------------------------------------
// mmp_state - paging and mode registers
// Applies one decoded command and reports the effective window mapping.
// ----------------------------------------------------------------------------
module mmp_state (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   apply,
  input  mmp_pkg::cmd_t                          cmd,
  output mmp_pkg::mode_regs_t                    regs,
  output mmp_pkg::mode_regs_t                    regs_next,
  output logic [mmp_pkg::NumWindows-1:0][7:0]    eff_page,
  output logic [mmp_pkg::NumWindows-1:0]         eff_ram
);
  import mmp_pkg::*;

  logic [NumWindows-1:0][7:0] seg_page;
  logic [NumWindows-1:0][7:0] seg_page_next;
  logic [NumWindows-1:0]      seg_ram;
  logic [NumWindows-1:0]      seg_ram_next;

  always_comb begin
    seg_page_next = seg_page;
    seg_ram_next  = seg_ram;
    regs_next     = regs;
    unique case (cmd.kind)
      CMD_SHADOW: regs_next.shadow = cmd.value;
      CMD_MGR:    regs_next.mgr    = cmd.value;
      CMD_EXT:    regs_next.ext    = cmd.value;
      CMD_PAGE: begin
        seg_page_next[cmd.win] = cmd.page;
        seg_ram_next[cmd.win]  = cmd.ram;
      end
      CMD_LEGACY: begin
        seg_page_next[NumWindows-1] = {5'b00000, cmd.value[2:0]};
        seg_ram_next[NumWindows-1]  = 1'b1;
        seg_page_next[0]            = {seg_page[0][7:1], cmd.value[4]};
        seg_ram_next[0]             = 1'b0;
        regs_next.legacy            = cmd.value;
      end
      CMD_NVIDX:  regs_next.nvidx  = cmd.value;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_page <= {NumWindows{PageReset}};
      seg_ram  <= '0;
      regs     <= '0;
    end else if (apply) begin
      seg_page <= seg_page_next;
      seg_ram  <= seg_ram_next;
      regs     <= regs_next;
    end
  end

  // Effective mapping after the write: manager off, then force-RAM0, then ROM wrap
  always_comb begin
    for (int i = 0; i < NumWindows; i++) begin
      eff_page[i] = seg_page_next[i];
      eff_ram[i]  = seg_ram_next[i];
      if (!regs_next.mgr[0]) begin
        eff_page[i] = PageReset;
        eff_ram[i]  = 1'b0;
      end
      if (regs_next.ext[3] && i == 0) begin
        eff_page[i] = '0;
        eff_ram[i]  = 1'b1;
      end
      if (!eff_ram[i]) begin
        eff_page[i] = {{(8-RomPageW){1'b0}}, eff_page[i][RomPageW-1:0]};
      end
    end
  end

endmodule

### src/port_mapped_memory_pager.sv
// ----------------------------------------------------------------------------
// port_mapped_memory_pager - I/O port driven memory pager with NVRAM port
// Pipeline: an accepted port write is held in the input register, then
//   decode/update writes its result word into the result register.
// Throughput: one write per cycle when out_ready; stall holds a full stage 1.
// Reset: windows map ROM page 255 (reported as page 31), mode registers clear.
// ----------------------------------------------------------------------------
module port_mapped_memory_pager (
  input  logic        clk,
  input  logic        rst,
  // write channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] port_addr,
  input  logic [7:0]  write_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  win0_page,
  output logic        win0_ram,
  output logic [7:0]  win1_page,
  output logic        win1_ram,
  output logic [7:0]  win2_page,
  output logic        win2_ram,
  output logic [7:0]  win3_page,
  output logic        win3_ram,
  output logic        nvram_we,
  output logic [7:0]  nvram_addr,
  output logic [7:0]  nvram_data,
  output logic [1:0]  write_status
);
  import mmp_pkg::*;

  // Input register stage
  logic        s1_valid;
  logic [15:0] s1_port;
  logic [7:0]  s1_value;
  logic        s1_fire;

  // Decode and state
  cmd_t                       cmd;
  mode_regs_t                 regs;
  mode_regs_t                 regs_next;
  logic [NumWindows-1:0][7:0] eff_page;
  logic [NumWindows-1:0]      eff_ram;

  // Result register
  logic [NumWindows-1:0][7:0] res_page;
  logic [NumWindows-1:0]      res_ram;
  logic                       res_we;
  logic [7:0]                 res_addr;
  logic [7:0]                 res_data;
  status_t                    res_status;

  // The stage-1 word moves into the result register when that register is
  // empty or being drained this cycle; state commits in the same cycle.
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_port  <= port_addr;
      s1_value <= write_value;
    end
  end

  mmp_decode u_decode (
    .port_addr  (s1_port),
    .write_value(s1_value),
    .regs       (regs),
    .cmd        (cmd)
  );

  mmp_state u_state (
    .clk      (clk),
    .rst      (rst),
    .apply    (s1_fire),
    .cmd      (cmd),
    .regs     (regs),
    .regs_next(regs_next),
    .eff_page (eff_page),
    .eff_ram  (eff_ram)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_page   <= eff_page;
      res_ram    <= eff_ram;
      res_we     <= cmd.we;
      res_addr   <= regs_next.nvidx;
      res_data   <= cmd.we ? s1_value : 8'h00;
      res_status <= cmd.status;
    end
  end

  assign win0_page    = res_page[0];
  assign win0_ram     = res_ram[0];
  assign win1_page    = res_page[1];
  assign win1_ram     = res_ram[1];
  assign win2_page    = res_page[2];
  assign win2_ram     = res_ram[2];
  assign win3_page    = res_page[3];
  assign win3_ram     = res_ram[3];
  assign nvram_we     = res_we;
  assign nvram_addr   = res_addr;
  assign nvram_data   = res_data;
  assign write_status = res_status;

  // An NVRAM store only comes from a handled write
  a_we_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && nvram_we |-> write_status == ST_OK)
    else $error("nvram store with non-ok status");

  // No store means no data on the bus
  a_we_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !nvram_we |-> nvram_data == 8'h00)
    else $error("nvram data without store");

  // Window 0, as a ROM window, never reports a page beyond the ROM page count
  a_rom_wrap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !win0_ram |-> win0_page[7:RomPageW] == '0)
    else $error("window 0 rom page out of range");

  // Force-RAM0 in effect after a write means window 0 reports RAM page 0
  a_force_ram0: assert property (@(posedge clk) disable iff (rst)
    s1_fire && regs_next.ext[3] |=> win0_ram && win0_page == 8'h00)
    else $error("force ram0 not applied");

  // A stalled stage-1 word is kept
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_port) && $stable(s1_value))
    else $error("stage 1 word lost under stall");

endmodule
